// ===== sv/ipv4v_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4v_pkg
// shared codes and character helpers for the ipv4 text address validator
// ----------------------------------------------------------------------------
package ipv4v_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned OCTET_W = 8;
    localparam int unsigned ACC_W   = 12;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [ERR_W-1:0]   err_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [OCTET_W-1:0] octet_t;
    typedef logic [1:0]         phase_t;
    typedef logic [1:0]         field_idx_t;

    // scan phase codes
    localparam phase_t PH_LEAD  = 2'd0;
    localparam phase_t PH_BODY  = 2'd1;
    localparam phase_t PH_TRAIL = 2'd2;

    // verdict codes
    localparam err_t ERR_OK       = 3'd0;
    localparam err_t ERR_FORMAT   = 3'd1;
    localparam err_t ERR_TOO_BIG  = 3'd2;
    localparam err_t ERR_RANGE    = 3'd3;
    localparam err_t ERR_RESERVED = 3'd4;

    localparam char_t CH_DOT   = 8'd46;
    localparam char_t CH_ZERO  = 8'd48;
    localparam char_t CH_NINE  = 8'd57;
    localparam char_t CH_TAB   = 8'd9;
    localparam char_t CH_CR    = 8'd13;
    localparam char_t CH_SPACE = 8'd32;

    localparam octet_t OCTET_MAX   = 8'd255;
    localparam field_idx_t LAST_FIELD = 2'd3;

    function automatic logic is_ws(input char_t c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== sv/ipv4_text_address_validator.sv =====
// ----------------------------------------------------------------------------
// ipv4_text_address_validator
// checks dotted-decimal ipv4 host address text, one character per beat
// ----------------------------------------------------------------------------
// usage:
//   char channel: char_code / last_char with char_valid, char_stall. one
//   character per beat; last_char marks the final character of a text.
//   result channel: is_valid / error_code / address with result_valid,
//   result_stall. one result beat per text, none for other characters.
//   latency: the result beat is shown the cycle after the last character
//   is taken. throughput: one character per cycle while not stalled, set
//   by the single scan state update plus the result register.
//   the char side is stalled only while a result sits in the result
//   register and the receiver stalls it; other cycles take a character
//   even while a result is being handed over.
//   reset clears the scan state and result_valid, not the result payload;
//   after each verdict the scan state returns to its reset values for the next text.
// ----------------------------------------------------------------------------
module ipv4_text_address_validator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    output logic                                char_stall,
    input  logic [ipv4v_pkg::CHAR_W-1:0]        char_code,
    input  logic                                last_char,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                is_valid,
    output logic [ipv4v_pkg::ERR_W-1:0]         error_code,
    output logic [ipv4v_pkg::ADDR_W-1:0]        address
);

    ipv4v_pkg::phase_t     phase_reg, phase_next;
    ipv4v_pkg::field_idx_t field_index_reg, field_index_next;
    ipv4v_pkg::octet_t     field_value_reg, field_value_next;
    logic                  digit_seen_reg, digit_seen_next;
    ipv4v_pkg::addr_t      assembled_reg, assembled_next;
    logic                  format_bad_reg, format_bad_next;
    logic                  too_large_reg, too_large_next;

    logic                  result_valid_reg, result_valid_next;
    logic                  is_valid_reg, is_valid_next;
    ipv4v_pkg::err_t       error_code_reg, error_code_next;
    ipv4v_pkg::addr_t      address_reg, address_next;

    logic                  accept;

    assign char_stall = result_valid_reg && result_stall;
    assign accept     = char_valid && !char_stall;

    // per-character scan update
    always_comb
    begin
        logic [ipv4v_pkg::ACC_W-1:0] acc;
        logic                        body;
        phase_next       = phase_reg;
        field_index_next = field_index_reg;
        field_value_next = field_value_reg;
        digit_seen_next  = digit_seen_reg;
        assembled_next   = assembled_reg;
        format_bad_next  = format_bad_reg;
        too_large_next   = too_large_reg;
        body             = 1'b0;
        acc = {1'b0, field_value_reg, 3'b000} + {3'b000, field_value_reg, 1'b0}
            + {4'd0, char_code - ipv4v_pkg::CH_ZERO};

        if (phase_reg == ipv4v_pkg::PH_LEAD)
        begin
            if (!ipv4v_pkg::is_ws(char_code))
            begin
                phase_next = ipv4v_pkg::PH_BODY;
                body       = 1'b1;
            end
        end
        else if (phase_reg == ipv4v_pkg::PH_BODY)
        begin
            body = 1'b1;
        end
        else if (!ipv4v_pkg::is_ws(char_code))
        begin
            format_bad_next = 1'b1;
        end

        if (body)
        begin
            if (ipv4v_pkg::is_digit(char_code))
            begin
                field_value_next = (acc > {4'd0, ipv4v_pkg::OCTET_MAX}) ?
                                   ipv4v_pkg::OCTET_MAX : acc[ipv4v_pkg::OCTET_W-1:0];
                digit_seen_next  = 1'b1;
            end
            else if (char_code == ipv4v_pkg::CH_DOT)
            begin
                if (!digit_seen_reg || (field_index_reg == ipv4v_pkg::LAST_FIELD))
                begin
                    format_bad_next = 1'b1;
                end
                else
                begin
                    unique case (field_index_reg)
                        2'd0:    assembled_next[31:24] = assembled_reg[31:24] | field_value_reg;
                        2'd1:    assembled_next[23:16] = assembled_reg[23:16] | field_value_reg;
                        2'd2:    assembled_next[15:8]  = assembled_reg[15:8]  | field_value_reg;
                        default: assembled_next[7:0]   = assembled_reg[7:0]   | field_value_reg;
                    endcase
                    if (field_value_reg == ipv4v_pkg::OCTET_MAX)
                    begin
                        too_large_next = 1'b1;
                    end
                    field_index_next = field_index_reg + 2'd1;
                    field_value_next = '0;
                    digit_seen_next  = 1'b0;
                end
            end
            else if (ipv4v_pkg::is_ws(char_code))
            begin
                phase_next = ipv4v_pkg::PH_TRAIL;
            end
            else
            begin
                format_bad_next = 1'b1;
            end
        end
    end

    // verdict on the final character
    always_comb
    begin
        ipv4v_pkg::addr_t addr;
        logic             net_ok;
        logic             local_ok;
        addr = {assembled_next[31:8], assembled_next[7:0] | field_value_next};
        if (!addr[31])
        begin
            net_ok   = addr[31:24] != 8'd0;
            local_ok = (addr[23:0] != 24'd0) && (addr[23:0] != 24'hFFFFFF);
        end
        else if (addr[31:30] == 2'b10)
        begin
            net_ok   = addr[31:16] != 16'd0;
            local_ok = (addr[15:0] != 16'd0) && (addr[15:0] != 16'hFFFF);
        end
        else if (addr[31:29] == 3'b110)
        begin
            net_ok   = addr[31:8] != 24'd0;
            local_ok = (addr[7:0] != 8'd0) && (addr[7:0] != 8'hFF);
        end
        else
        begin
            net_ok   = addr[31:8] != 24'd0;
            local_ok = addr[7:0] != 8'd0;
        end

        address_next = addr;
        if (format_bad_next || (phase_next == ipv4v_pkg::PH_LEAD) ||
            (field_index_next != ipv4v_pkg::LAST_FIELD) || !digit_seen_next)
        begin
            error_code_next = ipv4v_pkg::ERR_FORMAT;
            address_next    = '0;
        end
        else if (too_large_next || (field_value_next == ipv4v_pkg::OCTET_MAX))
        begin
            error_code_next = ipv4v_pkg::ERR_TOO_BIG;
        end
        else if (!(net_ok && local_ok))
        begin
            error_code_next = ipv4v_pkg::ERR_RANGE;
        end
        else if (addr[31:29] == 3'b111)
        begin
            error_code_next = ipv4v_pkg::ERR_RESERVED;
        end
        else
        begin
            error_code_next = ipv4v_pkg::ERR_OK;
        end
        is_valid_next = error_code_next == ipv4v_pkg::ERR_OK;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (accept && last_char)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ipv4v_pkg::PH_LEAD;
            field_index_reg  <= '0;
            field_value_reg  <= '0;
            digit_seen_reg   <= 1'b0;
            assembled_reg    <= '0;
            format_bad_reg   <= 1'b0;
            too_large_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                if (last_char)
                begin
                    phase_reg       <= ipv4v_pkg::PH_LEAD;
                    field_index_reg <= '0;
                    field_value_reg <= '0;
                    digit_seen_reg  <= 1'b0;
                    assembled_reg   <= '0;
                    format_bad_reg  <= 1'b0;
                    too_large_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg       <= phase_next;
                    field_index_reg <= field_index_next;
                    field_value_reg <= field_value_next;
                    digit_seen_reg  <= digit_seen_next;
                    assembled_reg   <= assembled_next;
                    format_bad_reg  <= format_bad_next;
                    too_large_reg   <= too_large_next;
                end
            end
        end
    end

    // result payload, loaded only when a verdict is taken
    always_ff @(posedge clk)
    begin
        if (accept && last_char)
        begin
            is_valid_reg   <= is_valid_next;
            error_code_reg <= error_code_next;
            address_reg    <= address_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign is_valid     = is_valid_reg;
    assign error_code   = error_code_reg;
    assign address      = address_reg;

endmodule

// ===== sv/ipv4v_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4v_checker
// port-level checks for the ipv4 text address validator
// ----------------------------------------------------------------------------
module ipv4v_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    input  logic                                char_stall,
    input  logic [ipv4v_pkg::CHAR_W-1:0]        char_code,
    input  logic                                last_char,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic                                is_valid,
    input  logic [ipv4v_pkg::ERR_W-1:0]         error_code,
    input  logic [ipv4v_pkg::ADDR_W-1:0]        address
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
        result_valid && $stable(is_valid) && $stable(error_code) && $stable(address))
        else $error("result beat changed while stalled");

    // final character gives a result beat next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && last_char |=> result_valid)
        else $error("no result after final character");

    // verdict flag agrees with code
    a_flag_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_valid == (error_code == ipv4v_pkg::ERR_OK)))
        else $error("is_valid disagrees with error_code");

    // format errors carry a zero address
    a_format_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (error_code == ipv4v_pkg::ERR_FORMAT) |-> (address == '0))
        else $error("format error with nonzero address");

endmodule

bind ipv4_text_address_validator ipv4v_checker u_ipv4v_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_valid     (is_valid),
    .error_code   (error_code),
    .address      (address)
);

// ===== tb/ipv4_text_address_validator_tb.sv =====
// ----------------------------------------------------------------------------
// ipv4_text_address_validator_tb
// feeds address text one character per beat, with directed texts for the
// class split, oversized fields, format errors and whitespace, then random
// well-formed and broken addresses and raw noise. a local scan model
// predicts each verdict, and every result beat is checked against the
// oldest prediction. both sides idle and stall at random.
// ----------------------------------------------------------------------------
module ipv4_text_address_validator_tb;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam int unsigned NUM_CHARS   = 950;
    localparam int unsigned WELL_FORMED = 760;
    localparam int unsigned OCTET_CORNERS [17] =
        '{0, 1, 9, 10, 99, 100, 126, 127, 128, 191, 192, 223, 224, 239, 240, 254, 255};

    typedef struct {
        logic             ok;
        ipv4v_pkg::err_t  code;
        ipv4v_pkg::addr_t addr;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  char_valid = 1'b0;
    logic                  char_stall;
    ipv4v_pkg::char_t      char_code = '0;
    logic                  last_char = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  is_valid;
    ipv4v_pkg::err_t       error_code;
    ipv4v_pkg::addr_t      address;

    verdict_t              expected_verdicts[$];
    int unsigned           fail_count = 0;
    int unsigned           chars_sent = 0;
    int unsigned           idle_cycles = 0;
    int unsigned           hold_cycles = 0;
    int                    send_mode = 0;
    int                    recv_mode = 0;

    // scan model state
    ipv4v_pkg::phase_t     scan_phase;
    ipv4v_pkg::field_idx_t field_no;
    int unsigned           field_acc;
    logic                  have_digit;
    ipv4v_pkg::addr_t      octets;
    logic                  bad_format;
    logic                  octet_overflow;

    ipv4_text_address_validator u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .is_valid     (is_valid),
        .error_code   (error_code),
        .address      (address)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned draw_gap(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 12);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // scan model
    // ------------------------------------------------------------------
    function automatic logic blank_char(input ipv4v_pkg::char_t c);
        return (c == ipv4v_pkg::CH_SPACE) ||
               ((c >= ipv4v_pkg::CH_TAB) && (c <= ipv4v_pkg::CH_CR));
    endfunction

    function automatic void scan_reset();
        scan_phase     = ipv4v_pkg::PH_LEAD;
        field_no       = '0;
        field_acc      = 0;
        have_digit     = 1'b0;
        octets         = '0;
        bad_format     = 1'b0;
        octet_overflow = 1'b0;
    endfunction

    function automatic void close_field();
        octets |= ipv4v_pkg::addr_t'(field_acc[7:0])
                  << (8 * (ipv4v_pkg::LAST_FIELD - field_no));
        if (field_acc >= ipv4v_pkg::OCTET_MAX)
            octet_overflow = 1'b1;
    endfunction

    function automatic void take_body_char(input ipv4v_pkg::char_t c);
        int unsigned sum;
        if ((c >= ipv4v_pkg::CH_ZERO) && (c <= ipv4v_pkg::CH_NINE))
        begin
            sum = field_acc * 10 + int'(c) - int'(ipv4v_pkg::CH_ZERO);
            field_acc = (sum > ipv4v_pkg::OCTET_MAX) ? ipv4v_pkg::OCTET_MAX : sum;
            have_digit = 1'b1;
        end
        else if (c == ipv4v_pkg::CH_DOT)
        begin
            if (!have_digit || (field_no == ipv4v_pkg::LAST_FIELD))
                bad_format = 1'b1;
            else
            begin
                close_field();
                field_no++;
                field_acc = 0;
                have_digit = 1'b0;
            end
        end
        else if (blank_char(c))
            scan_phase = ipv4v_pkg::PH_TRAIL;
        else
            bad_format = 1'b1;
    endfunction

    function automatic void predict_char(input ipv4v_pkg::char_t c, input logic last);
        verdict_t         v;
        ipv4v_pkg::addr_t net_part;
        ipv4v_pkg::addr_t host_part;
        ipv4v_pkg::addr_t host_mask;
        if (scan_phase == ipv4v_pkg::PH_LEAD)
        begin
            if (!blank_char(c))
            begin
                scan_phase = ipv4v_pkg::PH_BODY;
                take_body_char(c);
            end
        end
        else if (scan_phase == ipv4v_pkg::PH_BODY)
            take_body_char(c);
        else if (!blank_char(c))
            bad_format = 1'b1;

        if (!last)
            return;

        if (bad_format || (scan_phase == ipv4v_pkg::PH_LEAD) ||
            (field_no != ipv4v_pkg::LAST_FIELD) || !have_digit)
        begin
            v.code = ipv4v_pkg::ERR_FORMAT;
            v.addr = '0;
        end
        else
        begin
            close_field();
            v.addr = octets;
            if (octet_overflow)
                v.code = ipv4v_pkg::ERR_TOO_BIG;
            else
            begin
                if (!v.addr[31])
                begin
                    net_part  = v.addr >> 24;
                    host_part = v.addr & 32'h00FF_FFFF;
                    host_mask = 32'h00FF_FFFF;
                end
                else if (v.addr[31:30] == 2'b10)
                begin
                    net_part  = v.addr >> 16;
                    host_part = v.addr & 32'h0000_FFFF;
                    host_mask = 32'h0000_FFFF;
                end
                else
                begin
                    // class c split for c, d and e; only the host mask differs
                    net_part  = v.addr >> 8;
                    host_part = v.addr & 32'h0000_00FF;
                    if (v.addr[31:29] == 3'b110)
                        host_mask = 32'h0000_00FF;
                    else if (v.addr[31:28] == 4'b1110)
                        host_mask = 32'h0FFF_FFFF;
                    else
                        host_mask = 32'hFFFF_FFFF;
                end
                if ((net_part > 0) && (host_part > 0) && (host_part < host_mask))
                    v.code = (v.addr >= 32'hE000_0000) ? ipv4v_pkg::ERR_RESERVED
                                                       : ipv4v_pkg::ERR_OK;
                else
                    v.code = ipv4v_pkg::ERR_RANGE;
            end
        end
        v.ok = (v.code == ipv4v_pkg::ERR_OK);
        expected_verdicts.push_back(v);
        scan_reset();
    endfunction

    // ------------------------------------------------------------------
    // char side
    // ------------------------------------------------------------------
    task automatic send_char(input ipv4v_pkg::char_t c, input logic last);
        int unsigned gap;
        gap = draw_gap(send_mode);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= last;
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
        predict_char(c, last);
    endtask

    task automatic send_chars(input ipv4v_pkg::char_t chars[$]);
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
    endtask

    function automatic void append_str(ref ipv4v_pkg::char_t q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(ipv4v_pkg::char_t'(s[i]));
    endfunction

    task automatic send_text(input string s);
        ipv4v_pkg::char_t q[$];
        append_str(q, s);
        send_chars(q);
    endtask

    task automatic wait_drain();
        char_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic ipv4v_pkg::char_t pick_blank();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? ipv4v_pkg::CH_SPACE : ipv4v_pkg::char_t'(ipv4v_pkg::CH_TAB + r);
    endfunction

    function automatic void append_octet(ref ipv4v_pkg::char_t q[$]);
        int unsigned v;
        string       s;
        case ($urandom_range(0, 5)) inside
            0: v = OCTET_CORNERS[$urandom_range(0, 16)];
            [1:3]: v = $urandom_range(0, 254);
            4: v = $urandom_range(0, 255);
            default: v = $urandom_range(256, 999);
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"0", s};
        append_str(q, s);
    endfunction

    function automatic void shuffle_modes();
        if ($urandom_range(0, 15) == 0)
        begin
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_valid_hosts();
        send_mode = 0;
        recv_mode = 0;
        send_text("10.1.2.3");
        send_text("128.0.0.1");
        send_text("192.168.0.254");
        send_text("001.02.3.4");
    endtask

    task automatic test_oversized_fields();
        send_mode = 1;
        send_text("255.1.1.1");
        send_text("1.2.3.255");
        send_text("1.2.3.0000000000256");
    endtask

    task automatic test_class_ranges();
        recv_mode = 1;
        send_text("0.1.2.3");
        send_text("10.0.0.0");
        send_text("192.168.1.0");
        send_text("224.0.0.1");
        send_text("254.254.254.254");
        send_text("240.1.1.0");
    endtask

    task automatic test_format_errors();
        ipv4v_pkg::char_t q[$];
        send_mode = 2;
        send_text("1.2.3");
        send_text("1.2.3.4.5");
        send_text("1..2.3");
        send_text("+1.2.3.4");
        send_text("1.2 .3.4");
        // nul and a high-bit character inside the body
        append_str(q, "1.2.");
        q.push_back(8'h00);
        q.push_back(8'hFF);
        send_chars(q);
    endtask

    task automatic test_whitespace();
        ipv4v_pkg::char_t q[$];
        send_text(" ");
        q = '{8'd11, 8'd12, ipv4v_pkg::CH_TAB, ipv4v_pkg::CH_CR, 8'd10};
        append_str(q, "8.8.8.8");
        q.push_back(ipv4v_pkg::CH_SPACE);
        q.push_back(8'd11);
        send_chars(q);
        send_text("1.2.3.4 x");
        wait_drain();
    endtask

    task automatic test_random_addresses();
        ipv4v_pkg::char_t q[$];
        send_mode = 1;
        recv_mode = 1;
        while (chars_sent < WELL_FORMED)
        begin
            q.delete();
            repeat ($urandom_range(0, 2)) q.push_back(pick_blank());
            for (int f = 0; f < 4; f++)
            begin
                append_octet(q);
                if (f < 3)
                    q.push_back(ipv4v_pkg::CH_DOT);
            end
            repeat ($urandom_range(0, 2)) q.push_back(pick_blank());
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: q[$urandom_range(0, q.size() - 1)] =
                           ipv4v_pkg::char_t'($urandom_range(0, 255));
                    1: q.delete($urandom_range(0, q.size() - 1));
                    2: q.insert($urandom_range(0, q.size()), pick_blank());
                    default: append_str(q, ".7");
                endcase
            end
            send_chars(q);
            shuffle_modes();
            if ($urandom_range(0, 24) == 0)
                wait_drain();
        end
    endtask

    task automatic test_random_noise();
        ipv4v_pkg::char_t q[$];
        while (chars_sent < NUM_CHARS)
        begin
            q.delete();
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 3))
                    0: q.push_back(ipv4v_pkg::CH_DOT);
                    1: q.push_back(ipv4v_pkg::char_t'($urandom_range(ipv4v_pkg::CH_ZERO,
                                                                     ipv4v_pkg::CH_NINE)));
                    default: q.push_back(ipv4v_pkg::char_t'($urandom_range(0, 255)));
                endcase
            end
            send_chars(q);
            shuffle_modes();
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none, actual %0b %0d %0h",
                             $time, is_valid, error_code, address);
                    fail_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    compare_field("is_valid", 32'(want.ok), 32'(is_valid));
                    compare_field("error_code", 32'(want.code), 32'(error_code));
                    compare_field("address", want.addr, address);
                end
                hold_cycles = draw_gap(recv_mode);
            end
            else if (hold_cycles > 0)
                hold_cycles--;
            result_stall <= (hold_cycles > 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        scan_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_hosts();
        test_oversized_fields();
        test_class_ranges();
        test_format_errors();
        test_whitespace();
        test_random_addresses();
        test_random_noise();
        char_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ipv4v_pkg.sv
sv/ipv4_text_address_validator.sv
sv/ipv4v_checker.sv
tb/ipv4_text_address_validator_tb.sv
